// ===== hw/rtl/prcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package prcd_pkg;

    localparam int RAM_BYTES       = 1024;
    localparam int ROW_BYTES       = 4;
    localparam int ROW_COUNT       = RAM_BYTES / ROW_BYTES;
    localparam int ROW_AW          = $clog2(ROW_COUNT);
    localparam int ENTRY_COUNT     = 256;
    localparam bit HIGH_BYTE_FIRST = 1'b1;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ENTRY_SIZE  = 3'd0,
        CFG_DECODE_MODE = 3'd1,
        CFG_RED_COUNT   = 3'd2,
        CFG_GREEN_COUNT = 3'd3,
        CFG_BLUE_COUNT  = 3'd4,
        CFG_RED_POS     = 3'd5,
        CFG_GREEN_POS   = 3'd6,
        CFG_BLUE_POS    = 3'd7
    } t_cfg_reg;

    // entry size codes
    localparam logic [1:0] SIZE_ONE      = 2'd0;
    localparam logic [1:0] SIZE_TWO      = 2'd1;
    localparam logic [1:0] SIZE_FOUR     = 2'd2;
    localparam logic [1:0] SIZE_FOUR_ALT = 2'd3;

    // decode modes
    localparam logic [2:0] MODE_STANDARD = 3'd0;
    localparam logic [2:0] MODE_INVERTED = 3'd1;
    localparam logic [2:0] MODE_IRGB1555 = 3'd2;
    localparam logic [2:0] MODE_RGBX     = 3'd3;
    localparam logic [2:0] MODE_XRGB_LO  = 3'd4;
    localparam logic [2:0] MODE_XRGB_HI  = 3'd5;
    localparam logic [2:0] MODE_XBGR_LO  = 3'd6;
    localparam logic [2:0] MODE_SPARE    = 3'd7;

    typedef struct packed {
        logic [1:0] entry_size;
        logic [2:0] mode;
        logic [3:0] red_count;
        logic [3:0] green_count;
        logic [3:0] blue_count;
        logic [4:0] red_pos;
        logic [4:0] green_pos;
        logic [4:0] blue_pos;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hw/rtl/prcd_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Palette byte store: one row holds four bytes. Rows never written read as zero.
module prcd_store (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rd_en,
    input  wire logic [prcd_pkg::ROW_AW-1:0] i_rd_row,
    output logic [31:0]                     o_rd_data,
    input  wire logic                       i_wr_en,
    input  wire logic [prcd_pkg::ROW_AW-1:0] i_wr_row,
    input  wire logic [31:0]                i_wr_data
);

    logic [31:0]                     r_mem [prcd_pkg::ROW_COUNT];
    logic [prcd_pkg::ROW_COUNT-1:0]  r_row_valid;
    logic [31:0]                     r_rd_data;
    logic                            r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_valid[i_wr_row] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_row_valid[i_rd_row];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : 32'd0;

endmodule

`default_nettype wire

// ===== hw/rtl/prcd_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prcd_decode (
    input  wire logic [31:0]         i_raw,
    input  wire prcd_pkg::t_cfg      i_cfg,
    output logic [7:0]               o_red,
    output logic [7:0]               o_green,
    output logic [7:0]               o_blue
);

    // repeat the n low bits from the top until 8 bits are filled
    function automatic logic [7:0] expand(input logic [7:0] v, input logic [3:0] n);
        logic [7:0] res;
        case (n) inside
            4'd0, 4'd1: res = {8{v[0]}};
            4'd2:       res = {4{v[1:0]}};
            4'd3:       res = {v[2:0], v[2:0], v[2:1]};
            4'd4:       res = {2{v[3:0]}};
            4'd5:       res = {v[4:0], v[4:2]};
            4'd6:       res = {v[5:0], v[5:4]};
            4'd7:       res = {v[6:0], v[6]};
            default:    res = v;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] field(input logic [31:0] raw, input logic [4:0] pos,
                                         input logic [3:0] n);
        logic [62:0] sh;
        sh = {31'd0, raw} >> pos;
        return expand(sh[7:0], n);
    endfunction

    function automatic logic [7:0] x5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    logic [31:0] w_src;
    logic        w_int;

    assign w_src = (i_cfg.mode == prcd_pkg::MODE_INVERTED) ? ~i_raw : i_raw;
    assign w_int = i_raw[15];

    always_comb begin
        unique case (i_cfg.mode)
            prcd_pkg::MODE_IRGB1555: begin
                o_red   = {i_raw[14:10], w_int, i_raw[14:13]};
                o_green = {i_raw[9:5],   w_int, i_raw[9:8]};
                o_blue  = {i_raw[4:0],   w_int, i_raw[4:3]};
            end
            prcd_pkg::MODE_RGBX: begin
                o_red   = x5({i_raw[15:12], i_raw[3]});
                o_green = x5({i_raw[11:8],  i_raw[2]});
                o_blue  = x5({i_raw[7:4],   i_raw[1]});
            end
            prcd_pkg::MODE_XRGB_LO: begin
                o_red   = x5({i_raw[11:8], i_raw[14]});
                o_green = x5({i_raw[7:4],  i_raw[13]});
                o_blue  = x5({i_raw[3:0],  i_raw[12]});
            end
            prcd_pkg::MODE_XRGB_HI: begin
                o_red   = x5({i_raw[14], i_raw[11:8]});
                o_green = x5({i_raw[13], i_raw[7:4]});
                o_blue  = x5({i_raw[12], i_raw[3:0]});
            end
            prcd_pkg::MODE_XBGR_LO: begin
                o_red   = x5({i_raw[3:0],  i_raw[12]});
                o_green = x5({i_raw[7:4],  i_raw[13]});
                o_blue  = x5({i_raw[11:8], i_raw[14]});
            end
            default: begin
                // standard and inverted extract; unused code falls here too
                o_red   = field(w_src, i_cfg.red_pos,   i_cfg.red_count);
                o_green = field(w_src, i_cfg.green_pos, i_cfg.green_count);
                o_blue  = field(w_src, i_cfg.blue_pos,  i_cfg.blue_count);
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/palette_ram_color_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/tready        tdata: byte_address, write_data; tuser: action
// m_axis    out        m_axis_tvalid/tready        tdata: read_data .. blue_level; tuser: color_valid
// cfg       in         i_cfg_valid/o_cfg_ready     i_cfg_index, i_cfg_data
//
// Each transaction reads the 4-byte row from the palette store, then in the merge step merges
// the written byte, writes the row back on a write and decodes the entry.
// Reset restores the default configuration and marks every row as zero at once; no sweep.
// A result waiting on m_axis holds the merge step until it is taken; the next
// input is accepted only once the state has returned to idle after the merge.
module palette_ram_color_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [9:0] byte_address, [17:10] write_data
    input  wire logic        s_axis_tuser,   // [0] action

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [7:0] read_data, [15:8] entry_index,
                                             // [23:16] red_level, [31:24] green_level,
                                             // [39:32] blue_level
    output logic             m_axis_tuser,   // [0] color_valid

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_MERGE = 2'b10
    } t_state;

    t_state          r_state, n_state;
    prcd_pkg::t_cfg  r_cfg;

    logic            r_action;
    logic [9:0]      r_addr;
    logic [7:0]      r_wdata;

    logic            r_out_valid;
    logic [39:0]     r_out_data;
    logic            r_out_user;

    logic            w_accept;
    logic            w_finish;
    logic [31:0]     w_row;
    logic [31:0]     w_merged;
    logic [31:0]     w_raw;
    logic [9:0]      w_idx;
    logic            w_in_range;
    logic            w_color;
    logic [7:0]      w_rd_byte;
    logic [7:0]      w_red, w_green, w_blue;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_finish      = (r_state == S_MERGE) && (!r_out_valid || m_axis_tready);
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.entry_size  <= prcd_pkg::SIZE_TWO;
            r_cfg.mode        <= prcd_pkg::MODE_STANDARD;
            r_cfg.red_count   <= 4'd5;
            r_cfg.green_count <= 4'd5;
            r_cfg.blue_count  <= 4'd5;
            r_cfg.red_pos     <= 5'd10;
            r_cfg.green_pos   <= 5'd5;
            r_cfg.blue_pos    <= 5'd0;
        end else if (i_cfg_valid) begin
            unique case (prcd_pkg::t_cfg_reg'(i_cfg_index))
                prcd_pkg::CFG_ENTRY_SIZE:  r_cfg.entry_size  <= i_cfg_data[1:0];
                prcd_pkg::CFG_DECODE_MODE: r_cfg.mode        <= i_cfg_data[2:0];
                prcd_pkg::CFG_RED_COUNT:   r_cfg.red_count   <= i_cfg_data[3:0];
                prcd_pkg::CFG_GREEN_COUNT: r_cfg.green_count <= i_cfg_data[3:0];
                prcd_pkg::CFG_BLUE_COUNT:  r_cfg.blue_count  <= i_cfg_data[3:0];
                prcd_pkg::CFG_RED_POS:     r_cfg.red_pos     <= i_cfg_data[4:0];
                prcd_pkg::CFG_GREEN_POS:   r_cfg.green_pos   <= i_cfg_data[4:0];
                prcd_pkg::CFG_BLUE_POS:    r_cfg.blue_pos    <= i_cfg_data[4:0];
                default:                   r_cfg             <= r_cfg;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_MERGE;
            S_MERGE: if (w_finish) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= s_axis_tuser;
            r_addr   <= s_axis_tdata[9:0];
            r_wdata  <= s_axis_tdata[17:10];
        end
    end

    prcd_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_row  (s_axis_tdata[9:2]),
        .o_rd_data (w_row),
        .i_wr_en   (w_finish && r_action),
        .i_wr_row  (r_addr[9:2]),
        .i_wr_data (w_merged)
    );

    // drop the written byte into its lane of the row
    always_comb begin
        w_merged = w_row;
        if (r_action) begin
            w_merged[8*r_addr[1:0] +: 8] = r_wdata;
        end
    end

    assign w_rd_byte = w_row[8*r_addr[1:0] +: 8];

    // gather the entry bytes, lowest address first or last as configured
    always_comb begin
        case (r_cfg.entry_size)
            prcd_pkg::SIZE_ONE: begin
                w_idx = r_addr;
                w_raw = {24'd0, w_merged[8*r_addr[1:0] +: 8]};
            end
            prcd_pkg::SIZE_TWO: begin
                w_idx = {1'b0, r_addr[9:1]};
                w_raw = prcd_pkg::HIGH_BYTE_FIRST
                      ? {16'd0, w_merged[16*r_addr[1] +: 8], w_merged[16*r_addr[1]+8 +: 8]}
                      : {16'd0, w_merged[16*r_addr[1] +: 16]};
            end
            default: begin
                w_idx = {2'b00, r_addr[9:2]};
                w_raw = prcd_pkg::HIGH_BYTE_FIRST
                      ? {w_merged[7:0], w_merged[15:8], w_merged[23:16], w_merged[31:24]}
                      : w_merged;
            end
        endcase
    end

    assign w_in_range = (32'(w_idx) < prcd_pkg::ENTRY_COUNT);
    assign w_color    = r_action && w_in_range;

    prcd_decode u_decode (
        .i_raw   (w_raw),
        .i_cfg   (r_cfg),
        .o_red   (w_red),
        .o_green (w_green),
        .o_blue  (w_blue)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_user <= w_color;
            r_out_data <= w_color
                        ? {w_blue, w_green, w_red, w_idx[7:0], 8'd0}
                        : {32'd0, (r_action ? 8'd0 : w_rd_byte)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire
